// ===== hdl/ojs_pkg.sv =====
// Package for the online path smoother: constants, command struct, weight function.
`timescale 1ns / 1ps
package ojs_pkg;

	localparam int BUF_DEF    = 32;
	localparam int WINDOW_DEF = 16;
	localparam int DATA_W     = 32;
	localparam int GAIN_W     = 10;
	localparam int ITER_W     = 5;
	localparam int WGT_W      = 17;
	localparam int FRAC_W     = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [GAIN_W-1:0] LAMBDA_RST = GAIN_W'(100);
	localparam logic [GAIN_W-1:0] BETA_RST   = GAIN_W'(1);
	localparam logic [ITER_W-1:0] ITER_RST   = ITER_W'(8);

	localparam logic [CFG_IDX_W-1:0] REG_LAMBDA = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BETA   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ITER   = 2'd2;

	localparam longint unsigned EXP_M1_Q32 = 64'd1580030169;
	localparam int TAYLOR_TERMS = 21;

	typedef struct packed {
		logic frame_ld;
		logic slide;
		logic circ_ld;
		logic acc_en;
		logic mult_en;
		logic div_ld;
		logic div_step;
		logic p_wr;
	} ojs_cmd_t;

	// width of the dividend in a cell
	function automatic int num_width(input int buf_len);
		return 50 + $clog2(buf_len) + 13;
	endfunction

	// Q1.16 Gaussian weight exp(-9k^2/window^2), zero beyond the window
	function automatic logic [WGT_W-1:0] gauss_weight(input int k, input int window);
		longint unsigned xq;
		longint unsigned f;
		longint unsigned term;
		longint unsigned r;
		longint sum;
		int n;
		if (k > window) begin
			return '0;
		end
		xq = (64'(9 * k * k) << 32) / 64'(window * window);
		n = int'(xq >> 32);
		f = xq & 64'hFFFF_FFFF;
		term = 64'd1 << 32;
		sum = longint'(term);
		for (int i = 1; i < TAYLOR_TERMS; i++) begin
			term = ((term * f) >> 32) / 64'(i);
			if (i % 2 == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		r = longint'(sum);
		for (int i = 0; i < n; i++) begin
			r = (r * EXP_M1_Q32 + (64'd1 << 31)) >> 32;
		end
		return WGT_W'((r + 64'd32768) >> 16);
	endfunction

endpackage

// ===== hdl/online_path_jacobi_smoother_top.sv =====
// Top level of the online camera-path smoother: ring of position cells plus sequencer.
`timescale 1ns / 1ps
// One sample in, one smoothed sample out per item. Each window position is a cell;
// per Jacobi iteration the solution values circulate once round the ring of BUF cells,
// then every cell forms its sums and runs a bit-serial divider on its num_width(BUF)-bit
// dividend (68 bits at BUF=32) in parallel. A new item is accepted only once the
// previous one has reached the output register. The first frame and zero iterations
// pass the sample through. The result sits in an output register so the next item
// can be taken while it waits.
module online_path_jacobi_smoother_top
	import ojs_pkg::*;
#(
	parameter int BUF    = BUF_DEF,
	parameter int WINDOW = WINDOW_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic signed [DATA_W-1:0] path_sample,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic signed [DATA_W-1:0] smoothed_sample,
	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data
);

	localparam int IW = $clog2(BUF);
	localparam int LW = $clog2(BUF + 1);

	ojs_cmd_t                 cmd;
	logic [LW-1:0]            pos, len;
	logic [GAIN_W-1:0]        lam, bet;
	logic                     out_load;
	logic signed [DATA_W-1:0] c_vec    [BUF];
	logic signed [DATA_W-1:0] p_vec    [BUF];
	logic signed [DATA_W-1:0] circ_vec [BUF];
	logic [IW-1:0]            idx_vec  [BUF];
	logic signed [DATA_W-1:0] res_q;

	assign cfg_ready       = 1'b1;
	assign smoothed_sample = res_q;

	ojs_ctrl #(
		.BUF(BUF)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.cmd        (cmd),
		.pos        (pos),
		.len        (len),
		.lambda_gain(lam),
		.beta_gain  (bet),
		.out_load   (out_load)
	);

	for (genvar k = 0; k < BUF; k++) begin : g_cell
		localparam int NB = (k + 1) % BUF;
		ojs_cell #(
			.BUF   (BUF),
			.WINDOW(WINDOW),
			.IDX   (k)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.pos        (pos),
			.len        (len),
			.lambda_gain(lam),
			.beta_gain  (bet),
			.sample     (path_sample),
			.nb_c       ((k == BUF - 1) ? path_sample : c_vec[NB]),
			.nb_p       ((k == BUF - 1) ? '0 : p_vec[NB]),
			.nb_circ    (circ_vec[NB]),
			.nb_idx     (idx_vec[NB]),
			.c_out      (c_vec[k]),
			.p_out      (p_vec[k]),
			.circ_out   (circ_vec[k]),
			.idx_out    (idx_vec[k])
		);
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			res_q <= p_vec[IW'(len - 1'b1)];
		end
	end

endmodule

// ===== hdl/ojs_cell.sv =====
// One window position: sample, solution, previous solution, MAC and bit-serial divider.
`timescale 1ns / 1ps
module ojs_cell
	import ojs_pkg::*;
#(
	parameter int BUF    = BUF_DEF,
	parameter int WINDOW = WINDOW_DEF,
	parameter int IDX    = 0
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  ojs_cmd_t                 cmd,
	input  logic [$clog2(BUF+1)-1:0] pos,
	input  logic [$clog2(BUF+1)-1:0] len,
	input  logic [GAIN_W-1:0]        lambda_gain,
	input  logic [GAIN_W-1:0]        beta_gain,
	input  logic signed [DATA_W-1:0] sample,
	input  logic signed [DATA_W-1:0] nb_c,
	input  logic signed [DATA_W-1:0] nb_p,
	input  logic signed [DATA_W-1:0] nb_circ,
	input  logic [$clog2(BUF)-1:0]   nb_idx,
	output logic signed [DATA_W-1:0] c_out,
	output logic signed [DATA_W-1:0] p_out,
	output logic signed [DATA_W-1:0] circ_out,
	output logic [$clog2(BUF)-1:0]   idx_out
);

	localparam int IW  = $clog2(BUF);
	localparam int LW  = $clog2(BUF + 1);
	localparam int PW  = WGT_W + 1 + DATA_W;
	localparam int SW  = PW + IW;
	localparam int SWW = WGT_W + IW + 1;
	localparam int DW  = SWW + GAIN_W + 1;
	localparam int NW  = num_width(BUF);

	logic signed [DATA_W-1:0] c_q, p_q, prev_q, circ_q;
	logic [IW-1:0]            idx_q;
	logic [WGT_W-1:0]         wtab [BUF];
	logic [IW-1:0]            pos_dist;
	logic [WGT_W-1:0]         w_sel;
	logic signed [PW-1:0]     prod_s1;
	logic [WGT_W-1:0]         w_s1;
	logic                     pv_s1;
	logic signed [SW-1:0]     s_q;
	logic [SWW-1:0]           sw_q;
	logic signed [SW+GAIN_W:0]       lams_s2;
	logic signed [DATA_W+GAIN_W:0]   betp_s2;
	logic [SWW+GAIN_W-1:0]           lamsw_s2;
	logic                     hasb;
	logic [DW-1:0]            den;
	logic signed [NW-1:0]     num;
	logic [DW-1:0]            d_q;
	logic [DW-1:0]            rem_q;
	logic [NW-1:0]            quo_q;
	logic                     neg_q;
	logic [DW:0]              trial;
	logic signed [NW-1:0]     qv;
	logic signed [DATA_W-1:0] qsat;

	for (genvar d = 0; d < BUF; d++) begin : g_wtab
		assign wtab[d] = gauss_weight(d, WINDOW);
	end

	assign c_out    = c_q;
	assign p_out    = p_q;
	assign circ_out = circ_q;
	assign idx_out  = idx_q;
	assign hasb     = LW'(IDX + 1) < len;

	always_comb begin
		if (IW'(IDX) >= idx_q) begin
			pos_dist = IW'(IDX) - idx_q;
		end else begin
			pos_dist = idx_q - IW'(IDX);
		end
		w_sel = (LW'(idx_q) < len) ? wtab[pos_dist] : '0;
	end

	always_comb begin
		den = DW'(32'd65536) + DW'(lamsw_s2)
			+ (hasb ? DW'({beta_gain, 16'd0}) : '0);
		num = (NW'(c_q) <<< FRAC_W) + NW'(lams_s2)
			+ (hasb ? (NW'(betp_s2) <<< FRAC_W) : '0)
			+ signed'(NW'(den >> 1));
		trial = {rem_q, quo_q[NW-1]};
		qv = neg_q ? signed'(~quo_q) : signed'(quo_q);
		if (qv > signed'(NW'(32'sh7FFF_FFFF))) begin
			qsat = 32'sh7FFF_FFFF;
		end else if (qv < -signed'(NW'(33'h0_8000_0000))) begin
			qsat = 32'sh8000_0000;
		end else begin
			qsat = DATA_W'(qv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pv_s1 <= 1'b0;
		end else begin
			pv_s1 <= cmd.acc_en;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q    <= '0;
			p_q    <= '0;
			prev_q <= '0;
		end else if (cmd.frame_ld) begin
			if (cmd.slide) begin
				c_q    <= nb_c;
				p_q    <= nb_c;
				prev_q <= nb_p;
			end else begin
				prev_q <= p_q;
				if (pos == LW'(IDX)) begin
					c_q <= sample;
					p_q <= sample;
				end else begin
					p_q <= c_q;
				end
			end
		end else if (cmd.p_wr && hasb) begin
			p_q <= qsat;
		end else if (cmd.p_wr && (LW'(IDX) < len)) begin
			p_q <= qsat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.circ_ld) begin
			circ_q <= p_q;
			idx_q  <= IW'(IDX);
			s_q    <= '0;
			sw_q   <= '0;
		end else begin
			if (cmd.acc_en) begin
				circ_q <= nb_circ;
				idx_q  <= nb_idx;
			end
			if (pv_s1) begin
				s_q  <= s_q + SW'(prod_s1);
				sw_q <= sw_q + SWW'(w_s1);
			end
		end

		prod_s1 <= signed'({1'b0, w_sel}) * circ_q;
		w_s1    <= w_sel;

		if (cmd.mult_en) begin
			lams_s2  <= signed'({1'b0, lambda_gain}) * s_q;
			betp_s2  <= signed'({1'b0, beta_gain}) * prev_q;
			lamsw_s2 <= lambda_gain * sw_q;
		end

		if (cmd.div_ld) begin
			d_q   <= den;
			rem_q <= '0;
			neg_q <= num[NW-1];
			quo_q <= num[NW-1] ? ~num : num;
		end else if (cmd.div_step) begin
			if (trial >= {1'b0, d_q}) begin
				rem_q <= DW'(trial - {1'b0, d_q});
				quo_q <= {quo_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial[DW-1:0];
				quo_q <= {quo_q[NW-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== hdl/ojs_ctrl.sv =====
// Sequencer: configuration registers, frame count, iteration schedule, output handshake.
`timescale 1ns / 1ps
module ojs_ctrl
	import ojs_pkg::*;
#(
	parameter int BUF = BUF_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	output logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     cfg_valid,
	input  logic [CFG_IDX_W-1:0]     cfg_index,
	input  logic [GAIN_W-1:0]        cfg_data,
	output ojs_cmd_t                 cmd,
	output logic [$clog2(BUF+1)-1:0] pos,
	output logic [$clog2(BUF+1)-1:0] len,
	output logic [GAIN_W-1:0]        lambda_gain,
	output logic [GAIN_W-1:0]        beta_gain,
	output logic                     out_load
);

	localparam int LW = $clog2(BUF + 1);
	localparam int NW = num_width(BUF);
	localparam int CW = $clog2(BUF + NW + 1);

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_LOAD  = 9'b000000010,
		ST_CIRC  = 9'b000000100,
		ST_DRAIN = 9'b000001000,
		ST_MULT  = 9'b000010000,
		ST_SUMS  = 9'b000100000,
		ST_DIV   = 9'b001000000,
		ST_WRITE = 9'b010000000,
		ST_OUT   = 9'b100000000
	} state_t;

	state_t              state_q;
	logic [LW-1:0]       fs_q, len_q;
	logic [CW-1:0]       cnt_q;
	logic [ITER_W-1:0]   it_q, iter_q;
	logic [GAIN_W-1:0]   lam_q, bet_q;
	logic                ov_q;
	logic                accept, slide;

	assign accept      = in_valid && !in_stall;
	assign in_stall    = state_q != ST_IDLE;
	assign slide       = fs_q == LW'(BUF);
	assign pos         = fs_q;
	assign len         = len_q;
	assign lambda_gain = lam_q;
	assign beta_gain   = bet_q;
	assign out_valid   = ov_q;
	assign out_load    = (state_q == ST_OUT) && (!ov_q || !out_stall);

	always_comb begin
		cmd          = '0;
		cmd.frame_ld = accept;
		cmd.slide    = slide;
		cmd.circ_ld  = state_q == ST_LOAD;
		cmd.acc_en   = state_q == ST_CIRC;
		cmd.mult_en  = state_q == ST_MULT;
		cmd.div_ld   = state_q == ST_SUMS;
		cmd.div_step = state_q == ST_DIV;
		cmd.p_wr     = state_q == ST_WRITE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lam_q  <= LAMBDA_RST;
			bet_q  <= BETA_RST;
			iter_q <= ITER_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_LAMBDA: lam_q  <= cfg_data;
				REG_BETA:   bet_q  <= cfg_data;
				REG_ITER:   iter_q <= cfg_data[ITER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fs_q    <= '0;
			len_q   <= '0;
			cnt_q   <= '0;
			it_q    <= '0;
			ov_q    <= 1'b0;
		end else begin
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						it_q  <= '0;
						len_q <= slide ? LW'(BUF) : fs_q + 1'b1;
						if (!slide) begin
							fs_q <= fs_q + 1'b1;
						end
						if (fs_q == '0 || iter_q == '0) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_LOAD;
						end
					end
				end
				ST_LOAD: begin
					cnt_q   <= '0;
					state_q <= ST_CIRC;
				end
				ST_CIRC: begin
					if (cnt_q == CW'(BUF - 1)) begin
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_DRAIN: state_q <= ST_MULT;
				ST_MULT:  state_q <= ST_SUMS;
				ST_SUMS: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == CW'(NW - 1)) begin
						state_q <= ST_WRITE;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_WRITE: begin
					it_q <= it_q + 1'b1;
					if (it_q + 1'b1 == iter_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_LOAD;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_fs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fs_q <= LW'(BUF))
		else $error("frame count past window length");
	a_first_pass: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fs_q == '0 |=> state_q == ST_OUT)
		else $error("first frame not passed straight through");
	a_circ_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CIRC |-> cnt_q < CW'(BUF))
		else $error("circulation count overrun");
	a_iter_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WRITE |-> it_q < iter_q)
		else $error("iteration count overrun");
`endif

endmodule
